@@ rtl/core/dwpid_pkg.sv @@
// shared types and constants of the two-wheel encoder speed regulator
// depends on nothing; used by the interfaces, the mac unit and the top level
package dwpid_pkg;

	typedef enum logic [1:0] {
		ACT_ENCODER = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_START   = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_INTEG_GAIN  = 3'd1,
		CFG_DERIV_GAIN  = 3'd2,
		CFG_TARGET      = 3'd3,
		CFG_BASE_DUTY   = 3'd4,
		CFG_LEFT_OFFSET = 3'd5
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] PROP_GAIN_RST   = 16'd3932;
	localparam logic [15:0] INTEG_GAIN_RST  = 16'd393;
	localparam logic [15:0] DERIV_GAIN_RST  = 16'd983;
	localparam logic [7:0]  TARGET_RST      = 8'd20;
	localparam logic [15:0] BASE_DUTY_RST   = 16'd12000;
	localparam logic [15:0] LEFT_OFFSET_RST = 16'd3000;

	// width of the Q.16 sum of three error products
	localparam int SUM_W = 35;
	// signed multiplier operand a: 16 bit error values and an unsigned 16 bit duty
	localparam int OPA_W = 17;

	localparam logic [15:0] CNT_MAX   = 16'hFFFF;
	localparam logic [14:0] TOTAL_MAX = 15'h7FFF;

	typedef struct packed {
		logic clr;
		logic acc_en;
	} mac_ctl_t;

endpackage

@@ rtl/core/dwpid_if.sv @@
// valid/ready channels of the regulator: input items and result items
// depends on dwpid_pkg
interface dwpid_in_if;
	logic                  valid;
	logic                  ready;
	dwpid_pkg::action_t    action;
	logic                  left_pulse;
	logic                  right_pulse;
	logic                  left_run;
	logic                  right_run;
	logic                  straight_run;

	modport source (output valid, action, left_pulse, right_pulse, left_run, right_run,
		straight_run, input ready);
	modport sink (input valid, action, left_pulse, right_pulse, left_run, right_run,
		straight_run, output ready);
endinterface

interface dwpid_out_if;
	logic               valid;
	logic               ready;
	logic        [15:0] left_duty;
	logic        [15:0] right_duty;
	logic        [14:0] travelled;
	logic signed [15:0] left_error;
	logic signed [15:0] right_error;
	logic               moving;

	modport source (output valid, left_duty, right_duty, travelled, left_error, right_error,
		moving, input ready);
	modport sink (input valid, left_duty, right_duty, travelled, left_error, right_error,
		moving, output ready);
endinterface

@@ rtl/core/dwpid_mac.sv @@
// shared signed multiplier with registered product and a product accumulator
// depends on dwpid_pkg
module dwpid_mac #(
	parameter int B_W = 16
) (
	input  logic                                  clk,
	input  dwpid_pkg::mac_ctl_t                   ctl,
	input  logic signed [dwpid_pkg::OPA_W-1:0]    a,
	input  logic        [B_W-1:0]                 b,
	output logic signed [dwpid_pkg::OPA_W+B_W-1:0] prod,
	output logic signed [dwpid_pkg::SUM_W-1:0]    acc
);
	import dwpid_pkg::*;

	localparam int P_W = OPA_W + B_W;

	logic signed [P_W:0]     full_w;
	logic signed [P_W-1:0]   prod_q;
	logic signed [SUM_W-1:0] acc_q;

	assign full_w = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		prod_q <= P_W'(full_w);
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + SUM_W'(prod_q);
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;
endmodule

@@ rtl/core/dual_wheel_encoder_pid_duty_core.sv @@
// top level of the two-wheel encoder speed regulator with pid gain and duty output
// depends on dwpid_pkg, dwpid_if and dwpid_mac
//
// Every input beat yields one result beat holding both duties, the travelled distance
// (average of the two saturating totals), the last errors and the moving flag. Encoder,
// start and stop beats update state at acceptance. A control tick taken while moving
// straight runs, per wheel, seven steps on one shared multiplier (proportional, integral
// and previous-error products, accumulate, gain update and clamp, base duty times gain,
// duty write); a tick at any other time only yields its result beat. The input is
// not ready while a beat is in work; a finished result sits in an output register, so a
// new beat is taken while it waits. Gains are unsigned Q1.GAIN_FRAC_BITS.
module dual_wheel_encoder_pid_duty_core #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dwpid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dwpid_pkg::CFG_DATA_W-1:0]   cfg_data,
	dwpid_in_if.sink                           item,
	dwpid_out_if.source                        result
);
	import dwpid_pkg::*;

	localparam int GAIN_W = GAIN_FRAC_BITS + 1;
	localparam int B_W    = (GAIN_W > 16) ? GAIN_W : 16;
	localparam int P_W    = OPA_W + B_W;
	localparam int SHL    = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
	localparam int SHR    = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;
	localparam int D_W    = SUM_W + SHL + 1;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MP    = 9'b000000010,
		S_MI    = 9'b000000100,
		S_MD    = 9'b000001000,
		S_ACC   = 9'b000010000,
		S_GAIN  = 9'b000100000,
		S_MDUTY = 9'b001000000,
		S_DUTY  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	logic   wheel_q;

	logic [15:0] prop_q, integ_q, deriv_q, base_q, loff_q;
	logic [7:0]  target_q;

	logic [GAIN_W-1:0]  l_gain_q, r_gain_q;
	logic signed [15:0] l_prev_q, r_prev_q, l_sum_q, r_sum_q;
	logic [15:0]        l_cnt_q, r_cnt_q, l_duty_q, r_duty_q;
	logic [14:0]        l_tot_q, r_tot_q;
	logic               moving_q, straight_q;
	logic signed [15:0] err_q;

	logic               ov_q;
	logic [15:0]        o_ld_q, o_rd_q;
	logic [14:0]        o_tr_q;
	logic signed [15:0] o_le_q, o_re_q;
	logic               o_mv_q;

	logic [GAIN_W-1:0]  cur_gain;
	logic signed [15:0] cur_prev, cur_sum;
	logic [15:0]        cur_cnt;
	logic signed [16:0] diff_w;
	logic signed [15:0] err_w;
	logic signed [16:0] sum_nx_w;
	logic signed [15:0] sum_sat_w;
	logic signed [D_W-1:0] d_w, g_w;
	logic [GAIN_W-1:0]  gain_nx_w;
	logic [15:0]        duty_w;
	logic [15:0]        trav_w;
	logic [15:0]        lstart_w;

	mac_ctl_t                mac_ctl;
	logic signed [OPA_W-1:0] op_a;
	logic [B_W-1:0]          op_b;
	logic signed [P_W-1:0]   prod;
	logic signed [SUM_W-1:0] acc;

	logic in_beat, out_free;

	assign in_beat  = item.valid && item.ready;
	assign out_free = !ov_q || result.ready;
	assign item.ready = (state_q == S_IDLE);

	// current wheel
	assign cur_gain = wheel_q ? r_gain_q : l_gain_q;
	assign cur_prev = wheel_q ? r_prev_q : l_prev_q;
	assign cur_sum  = wheel_q ? r_sum_q  : l_sum_q;
	assign cur_cnt  = wheel_q ? r_cnt_q  : l_cnt_q;

	assign diff_w = $signed({9'd0, target_q}) - $signed({1'b0, cur_cnt});
	assign err_w  = (diff_w < -17'sd32768) ? -16'sd32768 : 16'(diff_w);

	assign sum_nx_w  = {cur_sum[15], cur_sum} + {err_q[15], err_q};
	assign sum_sat_w = (sum_nx_w > 17'sd32767) ? 16'sd32767 :
		(sum_nx_w < -17'sd32768) ? -16'sd32768 : 16'(sum_nx_w);

	assign d_w = (D_W'(acc) <<< SHL) >>> SHR;
	assign g_w = d_w + $signed(D_W'(cur_gain));

	always_comb begin
		if (g_w[D_W-1]) begin
			gain_nx_w = '0;
		end else if (g_w > $signed(D_W'(GAIN_ONE))) begin
			gain_nx_w = GAIN_ONE;
		end else begin
			gain_nx_w = GAIN_W'(g_w);
		end
	end

	assign duty_w   = prod[GAIN_FRAC_BITS +: 16];
	assign trav_w   = {1'b0, l_tot_q} + {1'b0, r_tot_q};
	assign lstart_w = (item.left_run && base_q > loff_q) ? base_q - loff_q : 16'd0;

	// operand select for the shared multiplier
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		mac_ctl = '0;
		case (state_q)
			S_MP: begin
				op_a        = {err_w[15], err_w};
				op_b        = B_W'(prop_q);
				mac_ctl.clr = 1'b1;
			end
			S_MI: begin
				op_a           = {cur_sum[15], cur_sum};
				op_b           = B_W'(integ_q);
				mac_ctl.acc_en = 1'b1;
			end
			S_MD: begin
				op_a           = {cur_prev[15], cur_prev};
				op_b           = B_W'(deriv_q);
				mac_ctl.acc_en = 1'b1;
			end
			S_ACC: begin
				mac_ctl.acc_en = 1'b1;
			end
			S_MDUTY: begin
				op_a = {1'b0, base_q};
				op_b = B_W'(cur_gain);
			end
			default: begin
			end
		endcase
	end

	dwpid_mac #(
		.B_W(B_W)
	) u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.a    (op_a),
		.b    (op_b),
		.prod (prod),
		.acc  (acc)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q   <= PROP_GAIN_RST;
			integ_q  <= INTEG_GAIN_RST;
			deriv_q  <= DERIV_GAIN_RST;
			target_q <= TARGET_RST;
			base_q   <= BASE_DUTY_RST;
			loff_q   <= LEFT_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROP_GAIN:   prop_q   <= cfg_data;
				CFG_INTEG_GAIN:  integ_q  <= cfg_data;
				CFG_DERIV_GAIN:  deriv_q  <= cfg_data;
				CFG_TARGET:      target_q <= cfg_data[7:0];
				CFG_BASE_DUTY:   base_q   <= cfg_data;
				CFG_LEFT_OFFSET: loff_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wheel_q    <= 1'b0;
			l_gain_q   <= GAIN_ONE;
			r_gain_q   <= GAIN_ONE;
			l_prev_q   <= '0;
			r_prev_q   <= '0;
			l_sum_q    <= '0;
			r_sum_q    <= '0;
			l_cnt_q    <= '0;
			r_cnt_q    <= '0;
			l_tot_q    <= '0;
			r_tot_q    <= '0;
			l_duty_q   <= '0;
			r_duty_q   <= '0;
			moving_q   <= 1'b0;
			straight_q <= 1'b0;
			err_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_DONE;
						wheel_q <= 1'b0;
						case (item.action)
							ACT_ENCODER: begin
								if (item.left_pulse) begin
									if (l_cnt_q != CNT_MAX) l_cnt_q <= l_cnt_q + 16'd1;
									if (l_tot_q != TOTAL_MAX) l_tot_q <= l_tot_q + 15'd1;
								end
								if (item.right_pulse) begin
									if (r_cnt_q != CNT_MAX) r_cnt_q <= r_cnt_q + 16'd1;
									if (r_tot_q != TOTAL_MAX) r_tot_q <= r_tot_q + 15'd1;
								end
							end
							ACT_TICK: begin
								if (moving_q && straight_q) state_q <= S_MP;
							end
							ACT_START: begin
								l_duty_q   <= lstart_w;
								r_duty_q   <= item.right_run ? base_q : 16'd0;
								straight_q <= item.straight_run;
								moving_q   <= 1'b1;
								l_cnt_q    <= '0;
								r_cnt_q    <= '0;
							end
							ACT_STOP: begin
								l_duty_q <= '0;
								r_duty_q <= '0;
								moving_q <= 1'b0;
								l_cnt_q  <= '0;
								r_cnt_q  <= '0;
								l_tot_q  <= '0;
								r_tot_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_MP: begin
					err_q   <= err_w;
					state_q <= S_MI;
				end
				S_MI:    state_q <= S_MD;
				S_MD:    state_q <= S_ACC;
				S_ACC:   state_q <= S_GAIN;
				S_GAIN: begin
					if (wheel_q) begin
						r_gain_q <= gain_nx_w;
						r_prev_q <= err_q;
						r_sum_q  <= sum_sat_w;
						r_cnt_q  <= '0;
					end else begin
						l_gain_q <= gain_nx_w;
						l_prev_q <= err_q;
						l_sum_q  <= sum_sat_w;
						l_cnt_q  <= '0;
					end
					state_q <= S_MDUTY;
				end
				S_MDUTY: state_q <= S_DUTY;
				S_DUTY: begin
					if (wheel_q) begin
						r_duty_q <= duty_w;
						state_q  <= S_DONE;
					end else begin
						l_duty_q <= duty_w;
						wheel_q  <= 1'b1;
						state_q  <= S_MP;
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_ld_q <= l_duty_q;
			o_rd_q <= r_duty_q;
			o_tr_q <= trav_w[15:1];
			o_le_q <= l_prev_q;
			o_re_q <= r_prev_q;
			o_mv_q <= moving_q;
		end
	end

	assign result.valid       = ov_q;
	assign result.left_duty   = o_ld_q;
	assign result.right_duty  = o_rd_q;
	assign result.travelled   = o_tr_q;
	assign result.left_error  = o_le_q;
	assign result.right_error = o_re_q;
	assign result.moving      = o_mv_q;

	// checks
	a_tick_needs_straight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MP) |-> (moving_q && straight_q))
		else $error("regulation step while not moving straight");

	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(l_gain_q <= GAIN_ONE) && (r_gain_q <= GAIN_ONE))
		else $error("wheel gain above one");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !item.ready)
		else $error("input ready right after an accepted beat");

	a_done_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> ov_q)
		else $error("finished beat did not reach the result register");
endmodule
